@@ rtl/core/palette_pixel_unpack_map_top_defines.svh @@
// assertion helpers shared by the front, job queue and back end files
`ifndef PALETTE_PIXEL_UNPACK_MAP_TOP_DEFINES_SVH
`define PALETTE_PIXEL_UNPACK_MAP_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define PPUM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ppum assertion failed");
`define PPUM_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ppum condition must never hold");
`else
`define PPUM_ASSERT(name, clk, rst_n, prop)
`define PPUM_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

@@ rtl/core/ppum_pkg.sv @@
`timescale 1ns / 1ps
package ppum_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int WIDTH_BITS      = 16;

  localparam int PAL_AW     = $clog2(PALETTE_ENTRIES);
  localparam int ENTRY_W    = 32;
  localparam int ROW_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int PIX_CNT_W  = 4;
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

  localparam logic [8:0] PAL_LIMIT    = 9'(PALETTE_ENTRIES);
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] SLOT_EMPTY   = 8'hFF;
  localparam logic [2:0] MAP_NONE     = 3'd4;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_PAL   = 2'd1,
    MODE_PIXEL = 2'd2
  } ppum_mode_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_BIT_DEPTH = 3'd0,
    CFG_ROW_WIDTH = 3'd1,
    CFG_MAP_RED   = 3'd2,
    CFG_MAP_GREEN = 3'd3,
    CFG_MAP_BLUE  = 3'd4,
    CFG_MAP_ALPHA = 3'd5,
    CFG_OPT_ALPHA = 3'd6
  } ppum_cfg_idx_e;

  typedef struct packed {
    logic [1:0]       bit_depth;
    logic [ROW_W-1:0] row_width;
    logic [2:0]       map_red;
    logic [2:0]       map_green;
    logic [2:0]       map_blue;
    logic [2:0]       map_alpha;
    logic             optional_alpha;
  } ppum_cfg_t;

  // one packed byte as handed from the front to the back
  typedef struct packed {
    logic [7:0]           packed_byte;
    logic [PIX_CNT_W-1:0] pix_cnt;
    logic                 end_row;
    logic [2:0]           count;
    logic                 keep_alpha;
  } ppum_job_t;

  typedef struct packed {
    logic q_valid;
    logic q_full;
    logic back_busy;
  } ppum_stat_t;

endpackage

@@ rtl/core/ppum_if.sv @@
`timescale 1ns / 1ps
interface ppum_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] palette_index;
  logic [7:0] palette_red;
  logic [7:0] palette_green;
  logic [7:0] palette_blue;
  logic [7:0] palette_alpha;
  logic [7:0] packed_byte;

  modport source (output valid, mode, palette_index, palette_red, palette_green,
                  palette_blue, palette_alpha, packed_byte, input ready);
  modport sink   (input valid, mode, palette_index, palette_red, palette_green,
                  palette_blue, palette_alpha, packed_byte, output ready);
endinterface

interface ppum_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] slot_zero;
  logic [7:0] slot_one;
  logic [7:0] slot_two;
  logic [7:0] slot_three;
  logic [2:0] channel_count;
  logic       row_end;
  logic       last;

  modport source (output valid, slot_zero, slot_one, slot_two, slot_three,
                  channel_count, row_end, last, input ready);
  modport sink   (input valid, slot_zero, slot_one, slot_two, slot_three,
                  channel_count, row_end, last, output ready);
endinterface

interface ppum_cfg_if;
  import ppum_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

@@ rtl/core/ppum_ram.sv @@
`timescale 1ns / 1ps
module ppum_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/ppum_front.sv @@
`timescale 1ns / 1ps
`include "palette_pixel_unpack_map_top_defines.svh"
module ppum_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ppum_in_if.sink                           in_i,
  input  ppum_pkg::ppum_cfg_t               cfg_i,
  input  ppum_pkg::ppum_stat_t              stat_i,
  output logic                              push_o,
  output ppum_pkg::ppum_job_t               job_o,
  output logic                              pal_we_o,
  output logic [ppum_pkg::PAL_AW-1:0]       pal_waddr_o,
  output logic [ppum_pkg::ENTRY_W-1:0]      pal_wdata_o
);
  import ppum_pkg::*;

  logic [WIDTH_BITS-1:0] col_q, col_d;
  logic                  transl_q, transl_d;
  logic                  accept;
  logic                  pal_in_range;
  logic [WIDTH_BITS-1:0] width_eff;
  logic [WIDTH_BITS-1:0] remaining;
  logic [PIX_CNT_W-1:0]  per_byte;
  logic [PIX_CNT_W-1:0]  pix_cnt;
  logic                  end_row;
  logic [2:0]            map_cnt;
  logic                  keep_alpha;

  always_comb begin
    case (in_i.mode)
      MODE_PAL:   in_i.ready = !stat_i.q_valid && !stat_i.back_busy;
      MODE_PIXEL: in_i.ready = !stat_i.q_full;
      default:    in_i.ready = 1'b1;
    endcase
  end

  assign accept       = in_i.valid && in_i.ready;
  assign pal_in_range = {1'b0, in_i.palette_index} < PAL_LIMIT;

  // pixels this byte gives, limited by what the row still needs
  always_comb begin
    width_eff = WIDTH_BITS'(cfg_i.row_width);
    if (width_eff == '0) begin
      width_eff = WIDTH_BITS'(1);
    end
    remaining = (col_q < width_eff) ? (width_eff - col_q) : WIDTH_BITS'(1);
    per_byte  = PIX_CNT_W'(8) >> cfg_i.bit_depth;
    pix_cnt   = (remaining < WIDTH_BITS'(per_byte)) ? remaining[PIX_CNT_W-1:0] : per_byte;
    end_row   = remaining == WIDTH_BITS'(pix_cnt);
  end

  always_comb begin
    map_cnt = 3'((cfg_i.map_red < MAP_NONE)) + 3'((cfg_i.map_green < MAP_NONE))
            + 3'((cfg_i.map_blue < MAP_NONE)) + 3'((cfg_i.map_alpha < MAP_NONE));
    keep_alpha = !(cfg_i.optional_alpha && (map_cnt > 3'd1) && !transl_q);
    if (!keep_alpha) begin
      map_cnt = map_cnt - 3'd1;
    end
  end

  always_comb begin
    col_d    = col_q;
    transl_d = transl_q;
    if (accept) begin
      case (in_i.mode)
        MODE_START: begin
          col_d    = '0;
          transl_d = 1'b0;
        end
        MODE_PAL: begin
          if (pal_in_range && (in_i.palette_alpha != ALPHA_OPAQUE)) begin
            transl_d = 1'b1;
          end
        end
        MODE_PIXEL: begin
          col_d = end_row ? '0 : col_q + WIDTH_BITS'(pix_cnt);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      transl_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      transl_q <= transl_d;
    end
  end

  assign push_o            = accept && (in_i.mode == MODE_PIXEL);
  assign job_o.packed_byte = in_i.packed_byte;
  assign job_o.pix_cnt     = pix_cnt;
  assign job_o.end_row     = end_row;
  assign job_o.count       = map_cnt;
  assign job_o.keep_alpha  = keep_alpha;

  assign pal_we_o    = accept && (in_i.mode == MODE_PAL) && pal_in_range;
  assign pal_waddr_o = in_i.palette_index[PAL_AW-1:0];
  assign pal_wdata_o = {in_i.palette_red, in_i.palette_green, in_i.palette_blue,
                        in_i.palette_alpha};

  // a palette write must never overtake pixels still waiting for their lookup
  `PPUM_ASSERT(a_pal_write_drained, clk_i, rst_ni, pal_we_o |-> (!stat_i.q_valid && !stat_i.back_busy))

endmodule

@@ rtl/core/ppum_jobq.sv @@
`timescale 1ns / 1ps
`include "palette_pixel_unpack_map_top_defines.svh"
module ppum_jobq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ppum_pkg::ppum_job_t job_i,
  input  logic                pop_i,
  output ppum_pkg::ppum_job_t job_o,
  output logic                valid_o,
  output logic                full_o
);
  import ppum_pkg::*;

  ppum_job_t           slot_q [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [JOBQ_AW:0]    cnt_q, cnt_d;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == (JOBQ_AW+1)'(JOBQ_DEPTH);
  assign job_o   = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !(pop_i && valid_o)) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i && valid_o) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  `PPUM_ASSERT(a_no_overflow, clk_i, rst_ni, push_i |-> !full_o)

endmodule

@@ rtl/core/ppum_back.sv @@
`timescale 1ns / 1ps
`include "palette_pixel_unpack_map_top_defines.svh"
module ppum_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppum_pkg::ppum_cfg_t           cfg_i,
  input  ppum_pkg::ppum_job_t           job_i,
  input  logic                          job_valid_i,
  output logic                          pop_o,
  output logic                          busy_o,
  output logic                          pal_re_o,
  output logic [ppum_pkg::PAL_AW-1:0]   pal_raddr_o,
  input  logic [ppum_pkg::ENTRY_W-1:0]  pal_rdata_i,
  ppum_out_if.source                    out_o
);
  import ppum_pkg::*;

  // current byte being walked
  logic                 job_valid_q, job_valid_d;
  logic [7:0]           sh_q, sh_d;
  logic [PIX_CNT_W-1:0] rem_q, rem_d;
  logic                 end_row_q;
  logic [2:0]           count_q;
  logic                 keep_q;

  // lookup stage, palette data arrives here
  logic                 b_valid_q, b_valid_d;
  logic                 b_last_q, b_row_end_q, b_keep_q, b_oob_q;
  logic [2:0]           b_count_q;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_slot_q [4];
  logic [2:0]           out_count_q;
  logic                 out_row_end_q, out_last_q;

  logic                 b_adv, issue, take, last_pix;
  logic [7:0]           idx;
  logic [ENTRY_W-1:0]   entry;
  logic [7:0]           slot [4];

  assign b_adv    = b_valid_q && (!out_valid_q || out_o.ready);
  assign issue    = job_valid_q && (!b_valid_q || b_adv);
  assign last_pix = rem_q == PIX_CNT_W'(1);
  assign take     = job_valid_i && (!job_valid_q || (issue && last_pix));
  assign pop_o    = take;
  assign busy_o   = job_valid_q;

  // msb-first index extraction, the byte is shifted as pixels go out
  always_comb begin
    case (cfg_i.bit_depth)
      2'd0:    begin idx = {7'b0, sh_q[7]};   sh_d = sh_q << 1; end
      2'd1:    begin idx = {6'b0, sh_q[7:6]}; sh_d = sh_q << 2; end
      2'd2:    begin idx = {4'b0, sh_q[7:4]}; sh_d = sh_q << 4; end
      default: begin idx = sh_q;              sh_d = '0;        end
    endcase
  end

  assign pal_re_o    = issue;
  assign pal_raddr_o = idx[PAL_AW-1:0];

  always_comb begin
    job_valid_d = job_valid_q;
    rem_d       = rem_q;
    if (issue) begin
      rem_d = rem_q - 1'b1;
      if (last_pix) begin
        job_valid_d = 1'b0;
      end
    end
    if (take) begin
      job_valid_d = 1'b1;
      rem_d       = job_i.pix_cnt;
    end
  end

  always_comb begin
    b_valid_d = b_valid_q;
    if (b_adv) begin
      b_valid_d = 1'b0;
    end
    if (issue) begin
      b_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (b_adv) begin
      out_valid_d = 1'b1;
    end
  end

  // channel mapping, later channels win a shared slot
  always_comb begin
    entry = b_oob_q ? '0 : pal_rdata_i;
    for (int s = 0; s < 4; s++) begin
      slot[s] = SLOT_EMPTY;
    end
    if (cfg_i.map_red < MAP_NONE) begin
      slot[cfg_i.map_red[1:0]] = entry[31:24];
    end
    if (cfg_i.map_green < MAP_NONE) begin
      slot[cfg_i.map_green[1:0]] = entry[23:16];
    end
    if (cfg_i.map_blue < MAP_NONE) begin
      slot[cfg_i.map_blue[1:0]] = entry[15:8];
    end
    if (b_keep_q && (cfg_i.map_alpha < MAP_NONE)) begin
      slot[cfg_i.map_alpha[1:0]] = entry[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      rem_q       <= '0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      rem_q       <= rem_d;
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sh_q      <= job_i.packed_byte;
      end_row_q <= job_i.end_row;
      count_q   <= job_i.count;
      keep_q    <= job_i.keep_alpha;
    end else if (issue) begin
      sh_q <= sh_d;
    end
    if (issue) begin
      b_last_q    <= last_pix;
      b_row_end_q <= last_pix && end_row_q;
      b_count_q   <= count_q;
      b_keep_q    <= keep_q;
      b_oob_q     <= {1'b0, idx} >= PAL_LIMIT;
    end
    if (b_adv) begin
      for (int s = 0; s < 4; s++) begin
        out_slot_q[s] <= slot[s];
      end
      out_count_q   <= b_count_q;
      out_row_end_q <= b_row_end_q;
      out_last_q    <= b_last_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.slot_zero     = out_slot_q[0];
  assign out_o.slot_one      = out_slot_q[1];
  assign out_o.slot_two      = out_slot_q[2];
  assign out_o.slot_three    = out_slot_q[3];
  assign out_o.channel_count = out_count_q;
  assign out_o.row_end       = out_row_end_q;
  assign out_o.last          = out_last_q;

  `PPUM_ASSERT(a_row_end_on_last, clk_i, rst_ni, (out_valid_q && out_row_end_q) |-> out_last_q)
  `PPUM_ASSERT(a_lookup_held, clk_i, rst_ni, (b_valid_q && !b_adv) |=> b_valid_q)
  `PPUM_ASSERT_NEVER(a_empty_job, clk_i, rst_ni, job_valid_q && (rem_q == '0))

endmodule

@@ rtl/core/palette_pixel_unpack_map_top.sv @@
`timescale 1ns / 1ps
// indexed-colour pixel unpacker with palette lookup and channel mapping
// in_i: one transaction per item: image start, palette entry write or packed
//   byte of 1, 2, 4 or 8 bit indices, msb first
// out_o: one transaction per pixel: four mapped slots, channel count, row end
//   and a last flag on the final pixel of each byte
// cfg_i: always ready; user writes only while the block is idle (unchecked)
// a packed byte passes the job queue, the current byte register, the lookup
//   stage and the output register and leaves one pixel per cycle while out_o
//   is ready; the single palette read port and the back end walk set this
// bytes queue two deep ahead of the back end, so the input keeps flowing
//   while a byte is being walked out
// a palette write waits until every queued byte has done its lookups
// when the receiver stalls, the output register and the lookup stage hold,
//   then the queue fills and the input drops ready for bytes
// reset clears the column, the translucency flag, the config and the valid
//   flags; palette contents stay undefined until written
module palette_pixel_unpack_map_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppum_in_if.sink     in_i,
  ppum_out_if.source  out_o,
  ppum_cfg_if.sink    cfg_i
);
  import ppum_pkg::*;

  ppum_cfg_t            cfg_q;
  ppum_stat_t           stat;
  ppum_job_t            push_job, head_job;
  logic                 push, pop, q_valid, q_full, back_busy;
  logic                 pal_we, pal_re;
  logic [PAL_AW-1:0]    pal_waddr, pal_raddr;
  logic [ENTRY_W-1:0]   pal_wdata, pal_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_depth      <= 2'd3;
      cfg_q.row_width      <= ROW_W'(1);
      cfg_q.map_red        <= MAP_NONE;
      cfg_q.map_green      <= MAP_NONE;
      cfg_q.map_blue       <= MAP_NONE;
      cfg_q.map_alpha      <= MAP_NONE;
      cfg_q.optional_alpha <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        CFG_BIT_DEPTH: cfg_q.bit_depth      <= cfg_i.data[1:0];
        CFG_ROW_WIDTH: cfg_q.row_width      <= cfg_i.data[ROW_W-1:0];
        CFG_MAP_RED:   cfg_q.map_red        <= cfg_i.data[2:0];
        CFG_MAP_GREEN: cfg_q.map_green      <= cfg_i.data[2:0];
        CFG_MAP_BLUE:  cfg_q.map_blue       <= cfg_i.data[2:0];
        CFG_MAP_ALPHA: cfg_q.map_alpha      <= cfg_i.data[2:0];
        CFG_OPT_ALPHA: cfg_q.optional_alpha <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign stat.q_valid   = q_valid;
  assign stat.q_full    = q_full;
  assign stat.back_busy = back_busy;

  ppum_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_q),
    .stat_i      (stat),
    .push_o      (push),
    .job_o       (push_job),
    .pal_we_o    (pal_we),
    .pal_waddr_o (pal_waddr),
    .pal_wdata_o (pal_wdata)
  );

  ppum_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  ppum_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (pal_wdata),
    .re_i    (pal_re),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  ppum_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (head_job),
    .job_valid_i (q_valid),
    .pop_o       (pop),
    .busy_o      (back_busy),
    .pal_re_o    (pal_re),
    .pal_raddr_o (pal_raddr),
    .pal_rdata_i (pal_rdata),
    .out_o       (out_o)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import ppum_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int FILL_ENTRIES = 64;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] pal_idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] pix_byte;
  } in_item_t;

  localparam int ITEM_W = $bits(in_item_t);

  typedef struct packed {
    logic [3:0][7:0] slots;
    logic [2:0]      cnt;
    logic            row_end;
    logic            last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  ppum_in_if  in_if ();
  ppum_out_if out_if ();
  ppum_cfg_if cfg_if ();

  palette_pixel_unpack_map_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // drive side of the three channels
  in_item_t    drv = '0;
  logic        in_valid = 1'b0;
  logic        rx_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;

  assign in_if.valid         = in_valid;
  assign in_if.mode          = drv.mode;
  assign in_if.palette_index = drv.pal_idx;
  assign in_if.palette_red   = drv.red;
  assign in_if.palette_green = drv.green;
  assign in_if.palette_blue  = drv.blue;
  assign in_if.palette_alpha = drv.alpha;
  assign in_if.packed_byte   = drv.pix_byte;
  assign out_if.ready        = rx_ready;
  assign cfg_if.valid        = cfg_valid;
  assign cfg_if.addr         = cfg_addr;
  assign cfg_if.data         = cfg_data;

  // mirror of the block state
  logic [31:0] pal_rgba [256];
  logic [15:0] column;
  logic        alpha_seen;
  ppum_cfg_t   regs;

  pixel_t      pixel_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned quiet = 0;

  function automatic pixel_t place(pixel_t p, logic [2:0] map, logic [7:0] v);
    if (map < MAP_NONE) p.slots[map[1:0]] = v;
    return p;
  endfunction

  // low 32 and high 32 palette entries, the ones that get filled
  function automatic logic [7:0] low_high_idx(logic [5:0] r);
    return {{3{r[5]}}, r[4:0]};
  endfunction

  function automatic void unpack_byte(logic [7:0] b);
    int unsigned bits, per_byte, width, col, remaining, n, cnt, shift;
    logic        keep;
    logic [7:0]  idx;
    logic [31:0] e;
    pixel_t      p;
    bits     = 1 << regs.bit_depth;
    per_byte = 8 >> regs.bit_depth;
    width    = regs.row_width;
    if (width == 0) width = 1;
    col       = column;
    remaining = (col < width) ? width - col : 1;
    n         = (remaining < per_byte) ? remaining : per_byte;
    cnt = 0;
    if (regs.map_red < MAP_NONE) cnt++;
    if (regs.map_green < MAP_NONE) cnt++;
    if (regs.map_blue < MAP_NONE) cnt++;
    if (regs.map_alpha < MAP_NONE) cnt++;
    keep = !(regs.optional_alpha && cnt > 1 && !alpha_seen);
    if (!keep) cnt--;
    for (int unsigned k = 0; k < n; k++) begin
      shift = 8 - bits * (k + 1);
      idx   = 8'((b >> shift) & ((1 << bits) - 1));
      e     = pal_rgba[idx];
      p.slots = {4{SLOT_EMPTY}};
      p = place(p, regs.map_red, e[31:24]);
      p = place(p, regs.map_green, e[23:16]);
      p = place(p, regs.map_blue, e[15:8]);
      if (keep) p = place(p, regs.map_alpha, e[7:0]);
      p.cnt     = 3'(cnt);
      p.last    = (k + 1 == n);
      p.row_end = (k + 1 == n) && (n == remaining);
      pixel_q = {pixel_q, p};
    end
    column = (n == remaining) ? 16'd0 : 16'(col + n);
  endfunction

  function automatic void apply_item(in_item_t it);
    case (it.mode)
      MODE_START: begin
        column     = '0;
        alpha_seen = 1'b0;
      end
      MODE_PAL: begin
        if ({1'b0, it.pal_idx} < PAL_LIMIT) begin
          pal_rgba[it.pal_idx] = {it.red, it.green, it.blue, it.alpha};
          if (it.alpha != ALPHA_OPAQUE) alpha_seen = 1'b1;
        end
      end
      MODE_PIXEL: unpack_byte(it.pix_byte);
      default: ;
    endcase
  endfunction

  function automatic in_item_t mk_item(logic [1:0] mode);
    in_item_t it;
    it      = in_item_t'(ITEM_W'({$urandom(), $urandom()}));
    it.mode = mode;
    return it;
  endfunction

  // sender works in bursts, gaps fall at random against the block's work
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 20);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    drv      <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
    apply_item(it);
  endtask

  task automatic send_pal(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                          input logic [7:0] b, input logic [7:0] a);
    in_item_t it;
    it         = mk_item(MODE_PAL);
    it.pal_idx = idx;
    it.red     = r;
    it.green   = g;
    it.blue    = b;
    it.alpha   = a;
    send_item(it);
  endtask

  task automatic send_pixel(input logic [7:0] b);
    in_item_t it;
    it          = mk_item(MODE_PIXEL);
    it.pix_byte = b;
    send_item(it);
  endtask

  // no config write while a byte or a palette write may still be in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (HOLD_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input ppum_cfg_idx_e idx, input logic [15:0] data);
    cfg_addr  <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BIT_DEPTH: regs.bit_depth      = data[1:0];
      CFG_ROW_WIDTH: regs.row_width      = data;
      CFG_MAP_RED:   regs.map_red        = data[2:0];
      CFG_MAP_GREEN: regs.map_green      = data[2:0];
      CFG_MAP_BLUE:  regs.map_blue       = data[2:0];
      CFG_MAP_ALPHA: regs.map_alpha      = data[2:0];
      CFG_OPT_ALPHA: regs.optional_alpha = data[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // unused upper data bits carry noise
  task automatic configure(input ppum_cfg_t c);
    logic [15:0] junk;
    wait_idle();
    junk = 16'($urandom);
    write_reg(CFG_BIT_DEPTH, {junk[15:2], c.bit_depth});
    write_reg(CFG_ROW_WIDTH, c.row_width);
    write_reg(CFG_MAP_RED,   {junk[12:0], c.map_red});
    write_reg(CFG_MAP_GREEN, {junk[15:3], c.map_green});
    write_reg(CFG_MAP_BLUE,  {junk[13:1], c.map_blue});
    write_reg(CFG_MAP_ALPHA, {junk[14:2], c.map_alpha});
    write_reg(CFG_OPT_ALPHA, {junk[15:1], c.optional_alpha});
  endtask

  task automatic test_one_bit_rows();
    configure(ppum_cfg_t'{bit_depth: 2'd0, row_width: 16'd10, map_red: 3'd0,
                          map_green: 3'd1, map_blue: 3'd2, map_alpha: 3'd3,
                          optional_alpha: 1'b0});
    send_item(mk_item(MODE_START));
    send_pal(8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pal(8'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF);
    // second byte only finishes the ten pixel row
    send_pixel(8'hA5);
    send_pixel(8'h5A);
    send_item(mk_item(MODE_UNUSED));
  endtask

  task automatic test_two_bit_alpha_drop();
    // red and green share slot one, blue code above four, alpha first dropped
    configure(ppum_cfg_t'{bit_depth: 2'd1, row_width: 16'd3, map_red: 3'd1,
                          map_green: 3'd1, map_blue: 3'd7, map_alpha: 3'd0,
                          optional_alpha: 1'b1});
    send_item(mk_item(MODE_START));
    send_pal(8'd2, 8'h12, 8'h34, 8'h56, 8'hFF);
    send_pal(8'd3, 8'hAB, 8'hCD, 8'hEF, 8'hFF);
    send_pal(8'd0, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_pal(8'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h1B);
    send_pixel(8'hE4);
    send_pal(8'd3, 8'hAB, 8'hCD, 8'hEF, 8'h7F);
    send_pixel(8'h1B);
  endtask

  task automatic test_wide_depths();
    // zero width acts as one, alpha unmapped but still dropped from the count
    configure(ppum_cfg_t'{bit_depth: 2'd2, row_width: 16'd0, map_red: 3'd3,
                          map_green: 3'd2, map_blue: 3'd1, map_alpha: 3'd4,
                          optional_alpha: 1'b1});
    send_item(mk_item(MODE_START));
    send_pixel(8'h32);
    configure(ppum_cfg_t'{bit_depth: 2'd3, row_width: 16'hFFFF, map_red: 3'd3,
                          map_green: 3'd2, map_blue: 3'd1, map_alpha: 3'd0,
                          optional_alpha: 1'b0});
    send_pixel(8'h03);
    send_pixel(8'h00);
  endtask

  task automatic test_width_shrink();
    configure(ppum_cfg_t'{bit_depth: 2'd3, row_width: 16'd20, map_red: 3'd0,
                          map_green: 3'd5, map_blue: 3'd2, map_alpha: 3'd1,
                          optional_alpha: 1'b0});
    send_item(mk_item(MODE_START));
    send_pixel(8'h01);
    send_pixel(8'h02);
    send_pixel(8'h03);
    // column is now past the new width, next pixel closes the row
    wait_idle();
    write_reg(CFG_ROW_WIDTH, 16'd2);
    send_pixel(8'h02);
    send_pixel(8'h01);
  endtask

  task automatic test_palette_fill();
    int unsigned sel;
    logic [7:0]  a;
    send_item(mk_item(MODE_START));
    for (int i = 0; i < FILL_ENTRIES; i++) begin
      sel = $urandom_range(3);
      a   = (sel == 0) ? 8'h00 : (sel == 1) ? 8'($urandom) : ALPHA_OPAQUE;
      send_pal(low_high_idx(6'(i)), 8'($urandom), 8'($urandom), 8'($urandom), a);
    end
  endtask

  task automatic test_random_images();
    ppum_cfg_t   c;
    int unsigned r;
    logic [7:0]  a;
    for (int phase = 0; phase < 8; phase++) begin
      c.bit_depth = 2'($urandom_range(3));
      case (phase)
        0: c.row_width = 16'd1;
        1: c.row_width = 16'd0;
        2: c.row_width = 16'hFFFF;
        3: c.row_width = 16'($urandom);
        default: c.row_width = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 4))
                                                        : 16'($urandom_range(5, 40));
      endcase
      c.map_red   = ($urandom_range(2) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(3));
      c.map_green = ($urandom_range(2) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(3));
      c.map_blue  = ($urandom_range(2) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(3));
      c.map_alpha = ($urandom_range(2) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(3));
      c.optional_alpha = 1'($urandom_range(1));
      configure(c);
      if ($urandom_range(4) != 0) send_item(mk_item(MODE_START));
      for (int k = 0; k < 13; k++) begin
        r = $urandom_range(99);
        if (r < 70 || r >= 90) begin
          // full byte indices stay inside the filled entries
          if (c.bit_depth == 2'd3) send_pixel(low_high_idx(6'($urandom)));
          else send_pixel(8'($urandom));
        end else if (r < 80) begin
          a = ($urandom_range(3) == 0) ? 8'($urandom) : ALPHA_OPAQUE;
          send_pal(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), a);
        end else if (r < 85) begin
          send_item(mk_item(MODE_START));
        end else begin
          send_item(mk_item(MODE_UNUSED));
        end
        // sender holds off until the block has drained
        if (k == 6 && (phase % 3) == 1) wait_idle();
      end
    end
  endtask

  // receiver stall pattern: free running, random, periodic, long holds
  logic [9:0]  rx_cycle = '0;
  int unsigned rx_hold = 0;

  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (rx_hold != 0) begin
      rx_hold  <= rx_hold - 1;
      rx_ready <= 1'b0;
    end else begin
      case (rx_cycle[9:8])
        2'd0: rx_ready <= 1'b1;
        2'd1: rx_ready <= ($urandom_range(3) != 0);
        2'd2: rx_ready <= (rx_cycle[2:0] != 3'd5) && (rx_cycle[2:0] != 3'd6);
        default: begin
          if ($urandom_range(15) == 0) begin
            rx_hold  <= $urandom_range(4, 20);
            rx_ready <= 1'b0;
          end else begin
            rx_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic report_pixel(input string what, input pixel_t want, input pixel_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t %s: want %h %h %h %h cnt %0d end %b last %b", $realtime, what,
               want.slots[0], want.slots[1], want.slots[2], want.slots[3],
               want.cnt, want.row_end, want.last);
      $display("%0t %s: got  %h %h %h %h cnt %0d end %b last %b", $realtime, what,
               got.slots[0], got.slots[1], got.slots[2], got.slots[3],
               got.cnt, got.row_end, got.last);
    end
  endtask

  always @(posedge clk_i) begin : pixel_check
    pixel_t got;
    pixel_t want;
    if (rst_ni && out_if.valid && rx_ready) begin
      got.slots   = {out_if.slot_three, out_if.slot_two, out_if.slot_one, out_if.slot_zero};
      got.cnt     = out_if.channel_count;
      got.row_end = out_if.row_end;
      got.last    = out_if.last;
      if (pixel_q.size() == 0) begin
        report_pixel("unexpected pixel", '0, got);
      end else begin
        want = pixel_q.pop_front();
        if (got !== want) report_pixel("pixel mismatch", want, got);
      end
    end
  end

  // counts cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_if.ready) || (out_if.valid && rx_ready) ||
        (cfg_valid && cfg_if.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("FAIL palette_pixel_unpack_map_top");
        $finish;
      end
    end
  end

  initial begin
    foreach (pal_rgba[i]) pal_rgba[i] = '0;
    column     = '0;
    alpha_seen = 1'b0;
    regs       = ppum_cfg_t'{bit_depth: 2'd3, row_width: 16'd1, map_red: MAP_NONE,
                             map_green: MAP_NONE, map_blue: MAP_NONE,
                             map_alpha: MAP_NONE, optional_alpha: 1'b0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_one_bit_rows();
    test_two_bit_alpha_drop();
    test_wide_depths();
    test_width_shrink();
    test_palette_fill();
    test_random_images();

    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && pixel_q.size() == 0) begin
      $display("PASS palette_pixel_unpack_map_top");
    end else begin
      $display("FAIL palette_pixel_unpack_map_top");
    end
    $finish;
  end

endmodule
